>>> hw/rtl/iflk_pkg.sv
// Shared types, widths and constants of the ion fraction lookup.
package iflk_pkg;

  localparam int DENSITY_POINTS_DEF = 64;
  localparam int TEMP_POINTS_DEF    = 64;
  localparam int ION_KINDS_DEF      = 8;
  localparam int VALUE_BITS_DEF     = 20;

  localparam int FIELD_BITS     = 20;  // Q8.12 fields and registers
  localparam int ION_BITS       = 3;
  localparam int POINT_BITS     = 6;
  localparam int FRAC_BITS      = 33;  // Q0.32 with room for 1.0
  localparam int CFG_INDEX_BITS = 3;
  localparam int EXP_BITS       = 20;  // bits of the negated log fraction
  localparam int COORD_BITS     = 21;  // axis coordinate after the mass offset
  localparam int WEIGHT_BITS    = 32;  // unclamped Q.12 weight

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOG_H_MASS  = 3'd0,
    REG_DENS_START  = 3'd1,
    REG_DENS_INV    = 3'd2,
    REG_TEMP_START  = 3'd3,
    REG_TEMP_INV    = 3'd4
  } cfg_reg_t;

  // Control and write payload that rides along the addressing stages.
  typedef struct packed {
    mode_t                        mode;
    logic [ION_BITS-1:0]          ion;
    logic [POINT_BITS-1:0]        density_point;
    logic [POINT_BITS-1:0]        temp_point;
    logic signed [FIELD_BITS-1:0] table_word;
  } ctl_t;

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] m;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    m = n;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q0.32 factor 10^(-2^k / 4096), evaluated at elaboration.
  function automatic logic [63:0] pow_coef(int k);
    logic [63:0] c;
    c = 64'd429496730;
    if (k <= 12) begin
      for (int m = 12; m > k; m--) c = isqrt64(c << 32);
    end else begin
      for (int m = 13; m <= k; m++) c = (c * c + 64'h8000_0000) >> 32;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/iflk_if.sv
// Request and result channel interfaces of the ion fraction lookup.
interface iflk_req_if;
  import iflk_pkg::*;
  logic                         valid;
  logic                         ready;
  mode_t                        mode;
  logic [ION_BITS-1:0]          ion;
  logic [POINT_BITS-1:0]        density_point;
  logic [POINT_BITS-1:0]        temp_point;
  logic signed [FIELD_BITS-1:0] table_word;
  logic signed [FIELD_BITS-1:0] log_density;
  logic signed [FIELD_BITS-1:0] log_temp;

  modport source(output valid, mode, ion, density_point, temp_point, table_word,
                 log_density, log_temp, input ready);
  modport sink(input valid, mode, ion, density_point, temp_point, table_word,
               log_density, log_temp, output ready);
endinterface

interface iflk_rsp_if;
  import iflk_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] log_fraction;
  logic [FRAC_BITS-1:0]         fraction;

  modport source(output valid, log_fraction, fraction, input ready);
  modport sink(input valid, log_fraction, fraction, output ready);
endinterface

>>> hw/rtl/ion_fraction_bilinear_lookup.sv
// Ion fraction lookup: banked table, bilinear interpolation, power of ten.
//
// Requests arrive on req (valid/ready). A request with mode MODE_WRITE stores
// table_word at (ion, density_point, temp_point) and gives no result; a request
// with mode MODE_QUERY and an ion below ION_KINDS returns one result on rsp: the interpolated log10
// fraction in Q8.12 and ten to that power in Q0.32, saturated at 1.0.
// The table lives in four RAM banks split by the parity of the density and
// temperature indices, so the four corners of a cell are read in the same cycle
// and a request can enter every cycle while the pipeline is not stalled. A query
// passes through three axis stages, one RAM read, six interpolation stages
// and twenty stages of the power chain, one per exponent bit.
// Writes land in the RAM at the fourth stage, in request order, so a query
// always sees every write accepted before it.
// The whole pipeline moves on one enable: it advances when the result
// register is empty or being taken. When the receiver stalls, req.ready drops
// in the same cycle and every stage holds, so no request is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register reset
// values; the table itself is undefined until written. Configuration writes
// on cfg_write/cfg_index/cfg_data must only happen while the pipeline is empty.
module ion_fraction_bilinear_lookup #(
  parameter int DENSITY_POINTS = iflk_pkg::DENSITY_POINTS_DEF,
  parameter int TEMP_POINTS    = iflk_pkg::TEMP_POINTS_DEF,
  parameter int ION_KINDS      = iflk_pkg::ION_KINDS_DEF,
  parameter int VALUE_BITS     = iflk_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [iflk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iflk_pkg::FIELD_BITS-1:0]     cfg_data,
  iflk_req_if.sink                            req,
  iflk_rsp_if.source                          rsp
);
  import iflk_pkg::*;

  localparam int IWD   = (DENSITY_POINTS > 2) ? $clog2(DENSITY_POINTS) : 1;
  localparam int IWT   = (TEMP_POINTS > 2) ? $clog2(TEMP_POINTS) : 1;
  localparam int DH    = (DENSITY_POINTS + 1) / 2;
  localparam int TH    = (TEMP_POINTS + 1) / 2;
  localparam int BANK_DEPTH = ION_KINDS * DH * TH;
  localparam int ABW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Configuration registers.
  logic signed [FIELD_BITS-1:0] log_h_mass, dens_start, temp_start;
  logic [FIELD_BITS-1:0]        dens_inv, temp_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_h_mass <= '0;
      dens_start <= '0;
      dens_inv   <= FIELD_BITS'(4096);
      temp_start <= '0;
      temp_inv   <= FIELD_BITS'(4096);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOG_H_MASS: log_h_mass <= $signed(cfg_data);
        REG_DENS_START: dens_start <= $signed(cfg_data);
        REG_DENS_INV:   dens_inv   <= cfg_data;
        REG_TEMP_START: temp_start <= $signed(cfg_data);
        REG_TEMP_INV:   temp_inv   <= cfg_data;
        default: ;
      endcase
    end
  end

  // One enable for the whole pipeline; the last stage is the result register.
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Control pipeline alongside the three axis stages.
  ctl_t ctl_in, ctl1, ctl2, ctl3;
  logic v1, v2, v3;

  assign ctl_in = '{mode: req.mode, ion: req.ion, density_point: req.density_point,
                    temp_point: req.temp_point, table_word: req.table_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1 <= ctl_in; ctl2 <= ctl1; ctl3 <= ctl2;
    end
  end

  // The density axis works on hydrogen number density, not mass density.
  logic signed [COORD_BITS-1:0] dens_x, temp_x;
  assign dens_x = COORD_BITS'(req.log_density) - COORD_BITS'(log_h_mass);
  assign temp_x = COORD_BITS'(req.log_temp);

  logic [IWD-1:0] idx_d;
  logic [IWT-1:0] idx_t;
  logic signed [WEIGHT_BITS-1:0] w_d, w_t;

  iflk_axis #(.POINTS(DENSITY_POINTS)) u_axis_dens (
    .clk(clk), .adv(adv), .x(dens_x), .start(dens_start), .inv(dens_inv),
    .idx(idx_d), .w(w_d)
  );

  iflk_axis #(.POINTS(TEMP_POINTS)) u_axis_temp (
    .clk(clk), .adv(adv), .x(temp_x), .start(temp_start), .inv(temp_inv),
    .idx(idx_t), .w(w_t)
  );

  // Write qualification at the table stage.
  logic ion_ok, wr_ok, is_query;
  assign ion_ok   = 32'(ctl3.ion) < ION_KINDS;
  assign wr_ok    = v3 && (ctl3.mode == MODE_WRITE) && ion_ok
                    && (32'(ctl3.density_point) < DENSITY_POINTS)
                    && (32'(ctl3.temp_point) < TEMP_POINTS);
  assign is_query = v3 && (ctl3.mode == MODE_QUERY) && ion_ok;

  logic [VALUE_BITS-1:0] bank_data [4];
  logic [VALUE_BITS-1:0] wr_word;
  assign wr_word = VALUE_BITS'(ctl3.table_word);

  // Bank {pd, pt} holds the words whose density index has parity pd and whose
  // temperature index has parity pt, at row (index >> 1) on each axis.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PD = 1'(b / 2);
    localparam logic PT = 1'(b % 2);
    logic [IWD:0]   rd_sum;
    logic [IWT:0]   rt_sum;
    logic [ABW-1:0] raddr, waddr;
    logic           we;

    always_comb begin
      rd_sum = {1'b0, idx_d} + (IWD + 1)'(idx_d[0] ^ PD);
      rt_sum = {1'b0, idx_t} + (IWT + 1)'(idx_t[0] ^ PT);
      raddr  = ABW'((32'(ctl3.ion) * DH + 32'(rd_sum[IWD:1])) * TH + 32'(rt_sum[IWT:1]));
      waddr  = ABW'((32'(ctl3.ion) * DH + 32'(ctl3.density_point[POINT_BITS-1:1])) * TH
                    + 32'(ctl3.temp_point[POINT_BITS-1:1]));
      we     = adv && wr_ok && (ctl3.density_point[0] == PD) && (ctl3.temp_point[0] == PT);
    end

    iflk_ram #(.WIDTH(VALUE_BITS), .DEPTH(BANK_DEPTH)) u_ram (
      .clk(clk), .we(we), .waddr(waddr), .wdata(wr_word),
      .re(adv), .raddr(raddr), .rdata(bank_data[b])
    );
  end

  // Stage four: registered alongside the RAM read data.
  logic v4, ip4, jp4;
  logic signed [WEIGHT_BITS-1:0] t4, u4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= is_query;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ip4 <= idx_d[0];
      jp4 <= idx_t[0];
      t4  <= w_d;
      u4  <= w_t;
    end
  end

  logic v_lf;
  logic signed [FIELD_BITS-1:0] lf;

  iflk_interp #(.VALUE_BITS(VALUE_BITS)) u_interp (
    .clk(clk), .rst(rst), .adv(adv), .vin(v4), .ip(ip4), .jp(jp4),
    .t(t4), .u(u4), .bank_data(bank_data), .vout(v_lf), .r(lf)
  );

  iflk_pow10 u_pow10 (
    .clk(clk), .rst(rst), .adv(adv), .vin(v_lf), .r(lf),
    .vout(rsp.valid), .log_fraction(rsp.log_fraction), .fraction(rsp.fraction)
  );
endmodule

>>> hw/rtl/iflk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iflk_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/iflk_axis.sv
// One grid axis: offset, scale by the inverse step, then cell index and weight.
module iflk_axis #(
  parameter int POINTS = 64,
  localparam int IW    = (POINTS > 2) ? $clog2(POINTS) : 1
) (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic signed [iflk_pkg::COORD_BITS-1:0] x,
  input  logic signed [iflk_pkg::FIELD_BITS-1:0] start,
  input  logic [iflk_pkg::FIELD_BITS-1:0]        inv,
  output logic [IW-1:0]                          idx,
  output logic signed [iflk_pkg::WEIGHT_BITS-1:0] w
);
  import iflk_pkg::*;

  localparam int DXW  = COORD_BITS + 1;
  localparam int PW   = DXW + FIELD_BITS + 1;
  localparam int POSW = PW - 12;
  localparam int CELLW = POSW - 12;

  logic signed [DXW-1:0]   dx;
  logic signed [PW-1:0]    prod;
  logic signed [POSW-1:0]  pos;
  logic [CELLW-1:0]        cell_pos;
  logic [IW-1:0]           idx_next;
  logic signed [WEIGHT_BITS-1:0] w_next;

  always_comb begin
    pos      = prod[PW-1:12];
    cell_pos = pos[POSW-1:12];
    if (pos[POSW-1]) begin
      idx_next = '0;
    end else if (cell_pos > CELLW'(POINTS - 2)) begin
      idx_next = IW'(POINTS - 2);
    end else begin
      idx_next = cell_pos[IW-1:0];
    end
    w_next = WEIGHT_BITS'(pos) - $signed({(WEIGHT_BITS - IW - 12)'(0), idx_next, 12'd0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx   <= DXW'(x) - DXW'(start);
      prod <= dx * $signed({1'b0, inv});
      idx  <= idx_next;
      w    <= w_next;
    end
  end
endmodule

>>> hw/rtl/iflk_interp.sv
// Bilinear blend of the four corner words, rounding and saturation.
module iflk_interp #(
  parameter int VALUE_BITS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    adv,
  input  logic                                    vin,
  input  logic                                    ip,
  input  logic                                    jp,
  input  logic signed [iflk_pkg::WEIGHT_BITS-1:0] t,
  input  logic signed [iflk_pkg::WEIGHT_BITS-1:0] u,
  input  logic [VALUE_BITS-1:0]                   bank_data [4],
  output logic                                    vout,
  output logic signed [iflk_pkg::FIELD_BITS-1:0]  r
);
  import iflk_pkg::*;

  localparam int DW  = VALUE_BITS + 1;
  localparam int AW  = VALUE_BITS + 34;
  localparam int BW  = AW + 1;
  localparam int LOW = 28;
  localparam int HW  = BW - LOW;
  localparam int FW  = VALUE_BITS + 68;
  localparam int QW  = FW - 24;
  localparam logic signed [QW-1:0] QMAX = QW'(524287);
  localparam logic signed [QW-1:0] QMIN = -QW'(524288);

  logic                    v5, v6, v7, v8, v9;
  logic signed [VALUE_BITS-1:0] y1, y4;
  logic signed [DW-1:0]    d1, d2;
  logic signed [WEIGHT_BITS-1:0] t5, u5, u6, u7;
  logic signed [AW-1:0]    a6, b6, a7, a8;
  logic signed [BW-1:0]    diff;
  logic signed [AW-1:0]    td1, td2;
  logic signed [60:0]      pl;
  logic signed [HW+31:0]   ph;
  logic signed [FW-1:0]    f;
  logic signed [QW-1:0]    q;
  logic signed [FIELD_BITS-1:0] r_next;

  assign td1 = AW'(t5 * d1);
  assign td2 = AW'(t5 * d2);
  assign q   = f[FW-1:24];

  always_comb begin
    if (q > QMAX) r_next = FIELD_BITS'(QMAX);
    else if (q < QMIN) r_next = FIELD_BITS'(QMIN);
    else r_next = q[FIELD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; vout <= 1'b0;
    end else if (adv) begin
      v5 <= vin; v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; vout <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Corner order: (i,j), (i+1,j), (i+1,j+1), (i,j+1) by bank parity.
      y1 <= $signed(bank_data[{ip, jp}]);
      y4 <= $signed(bank_data[{ip, ~jp}]);
      d1 <= DW'($signed(bank_data[{~ip, jp}])) - DW'($signed(bank_data[{ip, jp}]));
      d2 <= DW'($signed(bank_data[{~ip, ~jp}])) - DW'($signed(bank_data[{ip, ~jp}]));
      t5 <= t;
      u5 <= u;
      a6 <= (AW'(y1) <<< 12) + td1;
      b6 <= (AW'(y4) <<< 12) + td2;
      u6 <= u5;
      a7 <= a6;
      diff <= BW'(b6) - BW'(a6);
      u7 <= u6;
      a8 <= a7;
      pl <= u7 * $signed({1'b0, diff[LOW-1:0]});
      ph <= u7 * $signed(diff[BW-1:LOW]);
      f <= (FW'(ph) <<< LOW) + FW'(pl) + (FW'(a8) <<< 12) + FW'(24'h80_0000);
      r <= r_next;
    end
  end
endmodule

>>> hw/rtl/iflk_pow10.sv
// Ten to the log fraction, one conditional Q0.32 factor per pipeline stage.
module iflk_pow10 (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   vin,
  input  logic signed [iflk_pkg::FIELD_BITS-1:0] r,
  output logic                                   vout,
  output logic signed [iflk_pkg::FIELD_BITS-1:0] log_fraction,
  output logic [iflk_pkg::FRAC_BITS-1:0]         fraction
);
  import iflk_pkg::*;

  logic                         v_q [EXP_BITS];
  logic signed [FIELD_BITS-1:0] r_q [EXP_BITS];
  logic [EXP_BITS-1:0]          e_q [EXP_BITS];
  logic [FRAC_BITS-1:0]         f_q [EXP_BITS];
  logic [EXP_BITS-1:0]          e0;

  // A non-negative log fraction leaves the exponent at zero, so 1.0 passes through.
  assign e0 = r[FIELD_BITS-1] ? EXP_BITS'(-(FIELD_BITS + 1)'(r)) : '0;

  for (genvar k = 0; k < EXP_BITS; k++) begin : g_stage
    localparam logic [31:0] COEF = 32'(pow_coef(k));
    logic                         vi;
    logic signed [FIELD_BITS-1:0] ri;
    logic [EXP_BITS-1:0]          ei;
    logic [FRAC_BITS-1:0]         fi;
    logic [64:0]                  prod;

    if (k == 0) begin : g_first
      assign vi = vin;
      assign ri = r;
      assign ei = e0;
      assign fi = FRAC_BITS'(64'h1_0000_0000);
    end else begin : g_next
      assign vi = v_q[k-1];
      assign ri = r_q[k-1];
      assign ei = e_q[k-1];
      assign fi = f_q[k-1];
    end

    assign prod = 65'(fi) * 65'(COEF) + 65'(32'h8000_0000);

    always_ff @(posedge clk) begin
      if (rst) v_q[k] <= 1'b0;
      else if (adv) v_q[k] <= vi;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_q[k] <= ri;
        e_q[k] <= ei;
        f_q[k] <= ei[k] ? prod[64:32] : fi;
      end
    end
  end

  assign vout         = v_q[EXP_BITS-1];
  assign log_fraction = r_q[EXP_BITS-1];
  assign fraction     = f_q[EXP_BITS-1];
endmodule

>>> hw/rtl/iflk_chk.sv
// Port-level checks of the ion fraction lookup, bound to the top level.
module iflk_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   req_ready,
  input logic                                   rsp_valid,
  input logic                                   rsp_ready,
  input logic signed [iflk_pkg::FIELD_BITS-1:0] rsp_log_fraction,
  input logic [iflk_pkg::FRAC_BITS-1:0]         rsp_fraction
);
  import iflk_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // The input side stalls exactly when a result is held back.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("request ready does not follow the result stall");

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_fraction)
      && $stable(rsp_fraction))
    else $error("stalled result changed");

  // Fraction is exactly 1.0 for a non-negative log fraction, and below it otherwise.
  a_unity: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_log_fraction >= 0) == (rsp_fraction == FRAC_BITS'(64'h1_0000_0000)))
      && (rsp_fraction <= FRAC_BITS'(64'h1_0000_0000)))
    else $error("fraction inconsistent with log fraction");
endmodule

bind ion_fraction_bilinear_lookup iflk_chk u_iflk_chk (
  .clk(clk),
  .rst(rst),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_log_fraction(rsp.log_fraction),
  .rsp_fraction(rsp.fraction)
);

>>> sim/ion_fraction_bilinear_lookup_test.sv
// Testbench of the ion fraction lookup: random and directed requests against a scoreboard.
module ion_fraction_bilinear_lookup_test;
  import iflk_pkg::*;

  localparam int DENS_N   = DENSITY_POINTS_DEF;
  localparam int TEMP_N   = TEMP_POINTS_DEF;
  localparam int ION_N    = ION_KINDS_DEF;
  localparam int DEPTH    = ION_N * DENS_N * TEMP_N;
  localparam int SETTLE   = 40;   // beyond the depth of the pipeline
  localparam int PHASE_N  = 45;   // stray writes or queries per configuration phase

  typedef struct {
    logic signed [FIELD_BITS-1:0] log_fraction;
    logic [FRAC_BITS-1:0]         fraction;
  } lookup_result_t;

  // The scoreboard keeps its own copy of the table and the registers, predicts
  // the result of every accepted query and checks results in arrival order.
  class lookup_scoreboard;
    logic signed [FIELD_BITS-1:0] table_words [DEPTH];
    bit                           written [DEPTH];
    longint                       h_mass, d_start, d_inv, t_start, t_inv;
    logic [63:0]                  coef [EXP_BITS];
    lookup_result_t               awaited [$];
    int                           errors;

    function new();
      h_mass  = 0;
      d_start = 0;
      d_inv   = 4096;
      t_start = 0;
      t_inv   = 4096;
      errors  = 0;
      foreach (written[n]) written[n] = 0;
      // Factors 10^(-2^k/4096): square roots downward from one tenth, squares upward.
      coef[12] = 64'd429496730;
      for (int k = 11; k >= 0; k--) coef[k] = root64(coef[k+1] << 32);
      for (int k = 13; k < EXP_BITS; k++)
        coef[k] = (coef[k-1] * coef[k-1] + 64'h8000_0000) >> 32;
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [FIELD_BITS-1:0] v);
      case (idx)
        REG_LOG_H_MASS: h_mass  = longint'($signed(v));
        REG_DENS_START: d_start = longint'($signed(v));
        REG_DENS_INV:   d_inv   = longint'(v);
        REG_TEMP_START: t_start = longint'($signed(v));
        REG_TEMP_INV:   t_inv   = longint'(v);
        default: ;
      endcase
    endfunction

    function int addr(int ion, int dp, int tp);
      return (ion * DENS_N + dp) * TEMP_N + tp;
    endfunction

    // Grid cell and unclamped weight on one axis.
    function void axis(longint x, longint start, longint inv, int points,
                       output int idx, output longint w);
      longint pos;
      longint id;
      pos = ((x - start) * inv) >>> 12;
      id  = pos < 0 ? 0 : (pos >>> 12);
      if (id > points - 2) id = points - 2;
      w   = pos - id * 4096;
      idx = int'(id);
    endfunction

    function void cell_of(logic signed [FIELD_BITS-1:0] ld, logic signed [FIELD_BITS-1:0] lt,
                          output int i, output int j);
      longint w;
      axis(longint'(ld) - h_mass, d_start, d_inv, DENS_N, i, w);
      axis(longint'(lt), t_start, t_inv, TEMP_N, j, w);
    endfunction

    function void note_request(mode_t mode, int ion, int dp, int tp,
                               logic signed [FIELD_BITS-1:0] word,
                               logic signed [FIELD_BITS-1:0] ld,
                               logic signed [FIELD_BITS-1:0] lt);
      int i, j;
      longint t, u, y1, y2, y3, y4, a, b;
      logic signed [127:0] aw, uw, dw, f;
      longint r;
      logic [EXP_BITS:0] e;
      logic [63:0] frac;
      lookup_result_t res;
      if (mode == MODE_WRITE) begin
        table_words[addr(ion, dp, tp)] = word;
        written[addr(ion, dp, tp)] = 1;
        return;
      end
      axis(longint'(ld) - h_mass, d_start, d_inv, DENS_N, i, t);
      axis(longint'(lt), t_start, t_inv, TEMP_N, j, u);
      y1 = table_words[addr(ion, i, j)];
      y2 = table_words[addr(ion, i + 1, j)];
      y3 = table_words[addr(ion, i + 1, j + 1)];
      y4 = table_words[addr(ion, i, j + 1)];
      a  = y1 * 4096 + t * (y2 - y1);
      b  = y4 * 4096 + t * (y3 - y4);
      aw = a;
      uw = u;
      dw = b - a;
      f  = ((aw * 4096 + uw * dw + (128'sd1 <<< 23)) >>> 24);
      if (f > 128'sd524287) r = 524287;
      else if (f < -128'sd524288) r = -524288;
      else r = longint'(f);
      frac = 64'd1 << 32;
      if (r < 0) begin
        e = (EXP_BITS + 1)'(-r);
        for (int k = 0; k < EXP_BITS; k++)
          if (e[k]) frac = (frac * coef[k] + 64'h8000_0000) >> 32;
      end
      res.log_fraction = FIELD_BITS'(r);
      res.fraction     = frac[FRAC_BITS-1:0];
      awaited.push_back(res);
    endfunction

    function void check_result(logic signed [FIELD_BITS-1:0] lf, logic [FRAC_BITS-1:0] fr);
      lookup_result_t exp_res;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: log_fraction %0d fraction %0d", lf, fr);
        return;
      end
      exp_res = awaited.pop_front();
      if (lf !== exp_res.log_fraction || fr !== exp_res.fraction) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: log_fraction %0d (expected %0d) fraction %0d (expected %0d)",
                   lf, exp_res.log_fraction, fr, exp_res.fraction);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [FIELD_BITS-1:0] cfg_data;
  int send_idle_pct;
  int recv_idle_pct;

  iflk_req_if req ();
  iflk_rsp_if rsp ();

  lookup_scoreboard sb = new();

  ion_fraction_bilinear_lookup DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are taken at the edge where valid and ready were both high.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.log_fraction, rsp.fraction);
  end

  // Presents one request, holds it until accepted and then lets the scoreboard
  // see it, so predictions follow the acceptance order.
  task automatic send(mode_t mode, int ion, int dp, int tp,
                      logic [FIELD_BITS-1:0] word, logic [FIELD_BITS-1:0] ld,
                      logic [FIELD_BITS-1:0] lt);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid         <= 1;
    req.mode          <= mode;
    req.ion           <= ION_BITS'(ion);
    req.density_point <= POINT_BITS'(dp);
    req.temp_point    <= POINT_BITS'(tp);
    req.table_word    <= word;
    req.log_density   <= ld;
    req.log_temp      <= lt;
    do @(posedge clk); while (!req.ready);
    sb.note_request(mode, ion, dp, tp, word, ld, lt);
  endtask

  // Table words lean toward small negative logs so that many results are not saturated.
  function automatic logic [FIELD_BITS-1:0] pick_word();
    if ($urandom_range(4) == 0) return FIELD_BITS'($urandom);
    return FIELD_BITS'(int'($urandom_range(60000)) - 50000);
  endfunction

  // A query must never read a word that was not written, so any corner of the
  // cell it will use that is still blank gets written first.
  task automatic query(int ion, logic [FIELD_BITS-1:0] ld, logic [FIELD_BITS-1:0] lt);
    int i, j;
    sb.cell_of(ld, lt, i, j);
    for (int di = 0; di < 2; di++)
      for (int dj = 0; dj < 2; dj++)
        if (!sb.written[sb.addr(ion, i + di, j + dj)])
          send(MODE_WRITE, ion, i + di, j + dj, pick_word(), FIELD_BITS'($urandom),
               FIELD_BITS'($urandom));
    send(MODE_QUERY, ion, $urandom_range(63), $urandom_range(63), FIELD_BITS'($urandom), ld, lt);
  endtask

  // Register writes happen only once the pipeline has drained; this is also
  // where the sender pauses until every result is in.
  task automatic configure(logic [FIELD_BITS-1:0] v [5]);
    req.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int n = 0; n < 5; n++) begin
      cfg_write <= 1;
      cfg_index <= CFG_INDEX_BITS'(n);
      cfg_data  <= v[n];
      @(posedge clk);
      sb.set_reg(cfg_reg_t'(n), v[n]);
    end
    cfg_write <= 0;
  endtask

  task automatic random_phase();
    logic [FIELD_BITS-1:0] ld, lt;
    for (int n = 0; n < PHASE_N; n++) begin
      if ($urandom_range(4) == 0) begin
        // Stray writes anywhere in the table.
        send(MODE_WRITE, $urandom_range(7), $urandom_range(63), $urandom_range(63),
             pick_word(), FIELD_BITS'($urandom), FIELD_BITS'($urandom));
      end else begin
        if ($urandom_range(3) == 0) begin
          ld = FIELD_BITS'($urandom);
          lt = FIELD_BITS'($urandom);
        end else begin
          // Mostly in a band from just below the start of the grid upward.
          ld = FIELD_BITS'(sb.h_mass + sb.d_start + int'($urandom_range(280000)) - 20000);
          lt = FIELD_BITS'(sb.t_start + int'($urandom_range(280000)) - 20000);
        end
        query($urandom_range(7), ld, lt);
      end
    end
  endtask

  initial begin
    logic [FIELD_BITS-1:0] v [5];
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 0;
    req.mode = MODE_WRITE;
    req.ion = '0;
    req.density_point = '0;
    req.temp_point = '0;
    req.table_word = '0;
    req.log_density = '0;
    req.log_temp = '0;
    rsp.ready = 0;
    send_idle_pct = 24;
    recv_idle_pct = 47;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: the extreme table words, a positive log that gives 1.0, the
    // field extremes of both coordinates and both saturation directions.
    send(MODE_WRITE, 7, 63, 63, 20'h7FFFF, 20'h80000, 20'h7FFFF);
    send(MODE_WRITE, 7, 62, 63, 20'h80000, 20'h7FFFF, 20'h80000);
    send(MODE_WRITE, 7, 62, 62, 20'h7FFFF, 0, 0);
    send(MODE_WRITE, 7, 63, 62, 20'h80000, 0, 0);
    query(7, 20'h7FFFF, 20'h7FFFF);
    query(7, 20'h7FFFF, 20'h80000);
    query(0, 20'h80000, 20'h80000);
    query(0, 20'h80000, 20'h7FFFF);
    query(0, 0, 0);
    query(1, 20'd4096, 20'd8192);
    send(MODE_WRITE, 2, 3, 3, 20'd4096, 0, 0);
    send(MODE_WRITE, 2, 4, 3, 20'd4096, 0, 0);
    send(MODE_WRITE, 2, 4, 4, 20'd4096, 0, 0);
    send(MODE_WRITE, 2, 3, 4, 20'd4096, 0, 0);
    query(2, 20'd14000, 20'd14000);
    send(MODE_WRITE, 3, 0, 0, 20'hFF000, 0, 0);  // log of one tenth
    send(MODE_WRITE, 3, 1, 0, 20'hFF000, 0, 0);
    send(MODE_WRITE, 3, 1, 1, 20'hFF000, 0, 0);
    send(MODE_WRITE, 3, 0, 1, 20'hFF000, 0, 0);
    query(3, 20'd100, 20'd100);
    query(3, 20'h80000, 20'd2000);

    random_phase();
    v = '{20'hE8000, 20'hF8000, 20'd8192, 20'h04000, 20'd40960};
    configure(v);
    random_phase();

    send_idle_pct = 47;
    recv_idle_pct = 24;
    v = '{20'h80000, 20'h7FFFF, 20'hFFFFF, 20'h80000, 20'd0};
    configure(v);
    random_phase();
    v = '{20'h7FFFF, 20'h80000, 20'd0, 20'h7FFFF, 20'hFFFFF};
    configure(v);
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    v = '{20'd0, 20'd0, 20'd1024, 20'd0, 20'd1024};
    configure(v);
    random_phase();

    req.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Generous bound on the whole run; reaching it means something hung.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/iflk_pkg.sv
hw/rtl/iflk_if.sv
hw/rtl/iflk_ram.sv
hw/rtl/iflk_axis.sv
hw/rtl/iflk_interp.sv
hw/rtl/iflk_pow10.sv
hw/rtl/ion_fraction_bilinear_lookup.sv
hw/rtl/iflk_chk.sv
sim/ion_fraction_bilinear_lookup_test.sv
